// ===== rtl/comment_aware_line_counter_macros.svh =====
// Assertion macros shared by the line counter RTL.
`ifndef COMMENT_AWARE_LINE_COUNTER_MACROS_SVH
`define COMMENT_AWARE_LINE_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define CLC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line counter check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define CLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line counter check failed");

`endif

// ===== rtl/clc_pkg.sv =====
`timescale 1ns / 1ps
package clc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  localparam count_t COUNT_MAX = '1;

  typedef enum logic [2:0] {
    PH_NORMAL     = 3'd0,
    PH_SLASH      = 3'd1,
    PH_BLOCK      = 3'd2,
    PH_BLOCK_STAR = 3'd3,
    PH_DASH       = 3'd4,
    PH_LINE       = 3'd5
  } phase_t;

  typedef logic [2:0] style_t;
  localparam style_t STYLE_NONE  = 3'd0;
  localparam style_t STYLE_PIPE  = 3'd1;
  localparam style_t STYLE_BLOCK = 3'd2;
  localparam style_t STYLE_HASH  = 3'd3;
  localparam style_t STYLE_DASH  = 3'd4;

  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_COMMENT_STYLE = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SKIP_BLANK    = 1'd1;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic       valid;
    logic [7:0] char_byte;
    logic       end_of_file;
  } step_t;

  typedef struct packed {
    count_t file_lines;
    logic   open_comment;
  } report_t;

  function automatic logic is_blank_byte(logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

endpackage

// ===== rtl/clc_if.sv =====
`timescale 1ns / 1ps
interface clc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_file;

  modport source (output valid, output char_byte, output end_of_file, input ready);
  modport sink (input valid, input char_byte, input end_of_file, output ready);
endinterface

interface clc_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] line_count;
  logic [31:0] total_count;
  logic        open_comment;

  modport source (output valid, output line_count, output total_count,
                  output open_comment, input ready);
  modport sink (input valid, input line_count, input total_count,
                input open_comment, output ready);
endinterface

// ===== rtl/clc_scan.sv =====
`timescale 1ns / 1ps
module clc_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  clc_pkg::step_t  step,
  input  clc_pkg::style_t comment_style,
  input  logic            skip_blank,
  output clc_pkg::report_t report
);
  import clc_pkg::*;

  phase_t phase_r, phase_nxt;
  logic   nonblank_r, nonblank_nxt;
  count_t file_lines_r, file_lines_nxt;

  logic [7:0] c;
  logic       nb_mid;
  logic       do_normal;
  logic       do_text;

  assign c = step.char_byte;

  always_comb begin
    phase_nxt      = phase_r;
    nonblank_nxt   = nonblank_r;
    file_lines_nxt = file_lines_r;
    nb_mid         = nonblank_r;
    do_normal      = 1'b0;
    do_text        = 1'b0;

    unique case (phase_r)
      PH_SLASH: begin
        if (c == CH_STAR) begin
          phase_nxt = PH_BLOCK;
        end else begin
          nb_mid    = 1'b1;
          do_normal = 1'b1;
        end
      end
      PH_BLOCK: begin
        if (c == CH_STAR) begin
          phase_nxt = PH_BLOCK_STAR;
        end
      end
      PH_BLOCK_STAR: begin
        if (c == CH_SLASH) begin
          phase_nxt = PH_NORMAL;
        end else if (c != CH_STAR) begin
          phase_nxt = PH_BLOCK;
        end
      end
      PH_DASH: begin
        if (c == CH_DASH) begin
          phase_nxt = PH_LINE;
        end else begin
          nb_mid    = 1'b1;
          do_normal = 1'b1;
        end
      end
      PH_LINE: begin
        if (c == CH_NL) begin
          phase_nxt = PH_NORMAL;
          do_text   = 1'b1;
        end
      end
      default: begin
        do_normal = 1'b1;
      end
    endcase

    nonblank_nxt = nb_mid;

    if (do_normal) begin
      phase_nxt = PH_NORMAL;
      priority if (comment_style == STYLE_PIPE && c == CH_PIPE) begin
        phase_nxt = PH_LINE;
      end else if (comment_style == STYLE_BLOCK && c == CH_SLASH) begin
        phase_nxt = PH_SLASH;
      end else if (comment_style == STYLE_HASH && c == CH_HASH) begin
        phase_nxt = PH_LINE;
      end else if (comment_style == STYLE_DASH && c == CH_DASH) begin
        phase_nxt = PH_DASH;
      end else begin
        do_text = 1'b1;
      end
    end

    if (do_text) begin
      if (c == CH_NL) begin
        if ((!skip_blank || nb_mid) && (file_lines_r != COUNT_MAX)) begin
          file_lines_nxt = file_lines_r + 1'b1;
        end
        nonblank_nxt = 1'b0;
      end else if (!is_blank_byte(c)) begin
        nonblank_nxt = 1'b1;
      end
    end

    if (step.end_of_file) begin
      phase_nxt      = PH_NORMAL;
      nonblank_nxt   = 1'b0;
      file_lines_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_NORMAL;
      nonblank_r   <= 1'b0;
      file_lines_r <= '0;
    end else if (step.valid) begin
      phase_r      <= phase_nxt;
      nonblank_r   <= nonblank_nxt;
      file_lines_r <= file_lines_nxt;
    end
  end

  assign report.file_lines   = file_lines_r;
  assign report.open_comment = (phase_r == PH_BLOCK) || (phase_r == PH_BLOCK_STAR) ||
                               (phase_r == PH_LINE);

endmodule

// ===== rtl/comment_aware_line_counter.sv =====
`timescale 1ns / 1ps
// Counts newline-terminated lines of a byte stream, one byte per word, with optional
// blank-line skipping and comment stripping. A word with end_of_file set closes the
// file and yields one result word carrying that file's count, the saturating running
// total and an open-comment flag. The block takes one word every cycle: each byte is
// registered, and as it leaves the input register the scanner updates its phase and
// counters while the result register loads, so a result word passes through the input
// register and then the result register. Only an end-of-file word can stall, and only
// while the result register holds a word not yet taken.
// Configuration should be written while no word is in flight.
module comment_aware_line_counter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  clc_byte_if.sink                             in_if,
  clc_result_if.source                         out_if,
  input  logic                                 cfg_we,
  input  logic [clc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [clc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);
  import clc_pkg::*;

  `include "comment_aware_line_counter_macros.svh"

  style_t style_r;
  logic   skip_r;

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_eof_r;

  logic        out_v_r;
  logic [31:0] out_line_r;
  logic [31:0] out_total_r;
  logic        out_open_r;

  count_t  all_lines_r, all_lines_nxt;
  logic [COUNT_WIDTH:0] sum;

  logic    out_free;
  logic    advance;
  logic    emit;
  step_t   step;
  report_t rep;

  assign out_free = !out_v_r || out_if.ready;
  assign advance  = in_v_r && (!in_eof_r || out_free);
  assign emit     = advance && in_eof_r;
  assign in_if.ready = !in_v_r || advance;

  assign step.valid       = advance;
  assign step.char_byte   = in_byte_r;
  assign step.end_of_file = in_eof_r;

  clc_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .comment_style (style_r),
    .skip_blank    (skip_r),
    .report        (rep)
  );

  always_comb begin
    sum = {1'b0, all_lines_r} + {1'b0, rep.file_lines};
    if (sum[COUNT_WIDTH]) begin
      all_lines_nxt = COUNT_MAX;
    end else begin
      all_lines_nxt = sum[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      style_r <= STYLE_NONE;
      skip_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COMMENT_STYLE: style_r <= cfg_wdata;
        CFG_SKIP_BLANK:    skip_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
    if (in_if.ready && in_if.valid) begin
      in_byte_r <= in_if.char_byte;
      in_eof_r  <= in_if.end_of_file;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r     <= 1'b0;
      all_lines_r <= '0;
    end else begin
      if (emit) begin
        out_v_r     <= 1'b1;
        all_lines_r <= all_lines_nxt;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
    if (emit) begin
      out_line_r  <= OUT_WIDTH'(rep.file_lines);
      out_total_r <= OUT_WIDTH'(all_lines_nxt);
      out_open_r  <= rep.open_comment;
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.line_count   = out_line_r;
  assign out_if.total_count  = out_total_r;
  assign out_if.open_comment = out_open_r;

  `CLC_ASSERT_SAME(a_total_covers_file, out_v_r, out_total_r >= out_line_r)
  `CLC_ASSERT_NEXT(a_eof_clears_file, emit, rep.file_lines == '0 && !rep.open_comment)
  `CLC_ASSERT_NEXT(a_total_monotonic, rst_n, all_lines_r >= $past(all_lines_r))

endmodule
